// ----- src/fdpc_pkg.sv -----
package fdpc_pkg;

	// byte values: sync received, marker sent, duty after reset
	localparam logic signed [7:0] SYNC_BYTE = -8'sd86;
	localparam logic [7:0] MARKER_BYTE = 8'd2;
	localparam logic [7:0] DUTY_RESET = 8'd120;

	// membership breakpoints
	localparam int BP_NB = -15;
	localparam int BP_NM = -10;
	localparam int BP_NS = -7;
	localparam int BP_ZL = -2;
	localparam int BP_ZR = 2;
	localparam int BP_PS = 7;
	localparam int BP_PM = 10;
	localparam int BP_PB = 15;

	// unsigned q1.15 full scale
	localparam logic [15:0] ONE_Q15 = 16'd32768;

	// fuzzy set slots
	localparam int NUM_SETS = 5;
	localparam int SET_NB = 0;
	localparam int SET_NS = 1;
	localparam int SET_ZE = 2;
	localparam int SET_PS = 3;
	localparam int SET_PB = 4;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_CENTRE_NB = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CENTRE_NS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CENTRE_ZE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CENTRE_PS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CENTRE_PB = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PWM_FLOOR = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_PWM_CEIL = 3'd6;

	// divider sizes: magnitude of 256*sum, sum of degrees, quotient
	localparam int NUM_W = 34;
	localparam int DEN_W = 18;
	localparam int QUO_W = 16;
	localparam int DIV_CNT_W = 5;

	typedef logic [NUM_SETS-1:0][15:0] deg_vec_t;

	typedef struct packed {
		logic [NUM_SETS-1:0][7:0] centre;
		logic [7:0] pwm_floor;
		logic [7:0] pwm_ceiling;
	} cfg_t;

	typedef struct packed {
		logic signed [7:0] left_err;
		logic signed [7:0] right_err;
	} job_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_LOAD,
		BK_MAC,
		BK_DIV,
		BK_UPD,
		BK_EMIT
	} bk_state_t;

	// k/5 in q1.15, saturated at one
	function automatic logic [15:0] frac5(input logic [7:0] k);
		logic [15:0] r;
		case (k)
			8'd0: r = 16'd0;
			8'd1: r = 16'd6553;
			8'd2: r = 16'd13107;
			8'd3: r = 16'd19660;
			8'd4: r = 16'd26214;
			default: r = ONE_Q15;
		endcase
		return r;
	endfunction

	// k/3 in q1.15
	function automatic logic [15:0] frac3(input logic [7:0] k);
		logic [15:0] r;
		case (k)
			8'd0: r = 16'd0;
			8'd1: r = 16'd10922;
			8'd2: r = 16'd21845;
			default: r = ONE_Q15;
		endcase
		return r;
	endfunction

	// k/7 in q1.15
	function automatic logic [15:0] frac7(input logic [7:0] k);
		logic [15:0] r;
		case (k)
			8'd0: r = 16'd0;
			8'd1: r = 16'd4681;
			8'd2: r = 16'd9362;
			8'd3: r = 16'd14043;
			8'd4: r = 16'd18724;
			8'd5: r = 16'd23405;
			8'd6: r = 16'd28086;
			default: r = ONE_Q15;
		endcase
		return r;
	endfunction

	// k/2 in q1.15
	function automatic logic [15:0] frac2(input logic [7:0] k);
		logic [15:0] r;
		case (k)
			8'd0: r = 16'd0;
			8'd1: r = 16'd16384;
			default: r = ONE_Q15;
		endcase
		return r;
	endfunction

	// membership degrees of one error value
	function automatic deg_vec_t fdpc_degrees(input logic signed [7:0] e);
		deg_vec_t d;
		logic signed [8:0] ew;
		ew = {e[7], e};
		d = '0;
		if (ew <= BP_NM)
			d[SET_NB] = frac5(8'(BP_NM - ew));
		if (ew >= BP_NM && ew <= BP_NS)
			d[SET_NS] = frac3(8'(ew - BP_NM));
		else if (ew >= BP_NS && ew <= 0)
			d[SET_NS] = frac7(8'(-ew));
		if (ew >= BP_ZL && ew <= 0)
			d[SET_ZE] = frac2(8'(ew - BP_ZL));
		else if (ew > 0 && ew <= BP_ZR)
			d[SET_ZE] = frac2(8'(BP_ZR - ew));
		if (ew >= 0 && ew <= BP_PS)
			d[SET_PS] = frac7(8'(ew));
		else if (ew > BP_PS && ew <= BP_PM)
			d[SET_PS] = frac3(8'(BP_PM - ew));
		if (ew >= BP_PM)
			d[SET_PB] = frac5(8'(ew - BP_PM));
		return d;
	endfunction

endpackage

// ----- src/fdpc_if.sv -----
interface fdpc_rx_if;
	logic valid;
	logic ready;
	logic signed [7:0] rx_byte;
	modport source(output valid, output rx_byte, input ready);
	modport sink(input valid, input rx_byte, output ready);
endinterface

interface fdpc_tx_if;
	logic valid;
	logic ready;
	logic [7:0] tx_byte;
	logic last_of_frame;
	modport source(output valid, output tx_byte, output last_of_frame, input ready);
	modport sink(input valid, input tx_byte, input last_of_frame, output ready);
endinterface

interface fdpc_cfg_if;
	import fdpc_pkg::*;
	logic valid;
	logic ready;
	logic [CFG_IDX_W-1:0] index;
	logic [7:0] data;
	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

// ----- src/fuzzy_dual_pwm_controller.sv -----
// channel  dir  payload                      handshake
// rx       in   rx_byte (8 bit signed)       valid/ready, beat on both high
// tx       out  tx_byte, last_of_frame       valid/ready, beat on both high
// cfg      in   index (3 bit), data (8 bit)  valid/ready, ready always high
//
// a byte that only moves the arm flags queues nothing; the right error byte
// queues a job, and the back end takes one job at a time, running the 16-step
// divider at most once per channel plus a multiply-accumulate over five sets
// reset restores the centres, clamp limits, duties of 120 and clears the arm flags
// rx stalls only when JOB_DEPTH jobs wait; a stalled tx holds the back end
module fuzzy_dual_pwm_controller #(
	parameter int JOB_DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	fdpc_rx_if.sink rx,
	fdpc_tx_if.source tx,
	fdpc_cfg_if.sink cfg
);
	import fdpc_pkg::*;

	cfg_t cfg_q;
	logic push_valid;
	logic push_ready;
	job_t push_job;
	logic pop_valid;
	logic pop_ready;
	job_t pop_job;

	assign cfg.ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.centre[SET_NB] <= 8'hF3;
			cfg_q.centre[SET_NS] <= 8'hFB;
			cfg_q.centre[SET_ZE] <= 8'h00;
			cfg_q.centre[SET_PS] <= 8'h0A;
			cfg_q.centre[SET_PB] <= 8'h13;
			cfg_q.pwm_floor <= 8'd6;
			cfg_q.pwm_ceiling <= 8'd139;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_CENTRE_NB: cfg_q.centre[SET_NB] <= cfg.data;
				REG_CENTRE_NS: cfg_q.centre[SET_NS] <= cfg.data;
				REG_CENTRE_ZE: cfg_q.centre[SET_ZE] <= cfg.data;
				REG_CENTRE_PS: cfg_q.centre[SET_PS] <= cfg.data;
				REG_CENTRE_PB: cfg_q.centre[SET_PB] <= cfg.data;
				REG_PWM_FLOOR: cfg_q.pwm_floor <= cfg.data;
				REG_PWM_CEIL: cfg_q.pwm_ceiling <= cfg.data;
				default: ;
			endcase
		end
	end

	// frame parsing
	fdpc_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_job(push_job)
	);

	// pending update jobs
	fdpc_queue #(
		.DEPTH(JOB_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_job(push_job),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_job(pop_job)
	);

	// fuzzy engine and output beats
	fdpc_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_regs(cfg_q),
		.job_valid(pop_valid),
		.job_ready(pop_ready),
		.job(pop_job),
		.tx(tx)
	);
endmodule

// ----- src/fdpc_div.sv -----
module fdpc_div (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [fdpc_pkg::NUM_W-1:0] dividend,
	input  logic [fdpc_pkg::DEN_W-1:0] divisor,
	output logic done,
	output logic [fdpc_pkg::QUO_W-1:0] quotient
);
	import fdpc_pkg::*;

	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] dsr_q;
	logic [QUO_W-1:0] quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [DEN_W:0] shifted;
	logic [DEN_W+1:0] trial;

	// one restoring step: bring in next dividend bit, try subtract
	assign shifted = {rem_q, quo_q[QUO_W-1]};
	assign trial = {1'b0, shifted} - {2'b00, dsr_q};

	// quotient is known to fit, so the upper dividend bits start below the divisor
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[NUM_W-1:QUO_W];
			quo_q <= dividend[QUO_W-1:0];
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (!trial[DEN_W+1]) begin
				rem_q <= trial[DEN_W-1:0];
				quo_q <= {quo_q[QUO_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DEN_W-1:0];
				quo_q <= {quo_q[QUO_W-2:0], 1'b0};
			end
		end
	end

	// step counter and status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q <= '0;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == DIV_CNT_W'(QUO_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	assign done = done_q;
	assign quotient = quo_q;
endmodule

// ----- src/fdpc_front.sv -----
module fdpc_front (
	input  logic clk,
	input  logic arst_n,
	fdpc_rx_if.sink rx,
	output logic push_valid,
	input  logic push_ready,
	output fdpc_pkg::job_t push_job
);
	import fdpc_pkg::*;

	logic left_armed_q;
	logic right_armed_q;
	logic signed [7:0] left_error_q;
	logic is_sync;
	logic accept;
	logic signed [7:0] half_err;

	assign is_sync = (rx.rx_byte == SYNC_BYTE);
	assign accept = rx.valid && rx.ready;
	assign rx.ready = push_ready;

	// halve toward zero
	assign half_err = (rx.rx_byte + $signed({7'd0, rx.rx_byte[7]})) >>> 1;

	// a right error byte completes the frame
	assign push_valid = rx.valid && !is_sync && right_armed_q;
	assign push_job = '{left_err: left_error_q, right_err: half_err};

	// arm flags and kept left error
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_armed_q <= 1'b0;
			right_armed_q <= 1'b0;
			left_error_q <= '0;
		end else if (accept) begin
			if (!is_sync && right_armed_q) begin
				right_armed_q <= 1'b0;
			end else if (!is_sync && left_armed_q) begin
				left_error_q <= rx.rx_byte;
				left_armed_q <= 1'b0;
				right_armed_q <= 1'b1;
			end else if (is_sync) begin
				left_armed_q <= 1'b1;
			end
		end
	end
endmodule

// ----- src/fdpc_queue.sv -----
module fdpc_queue #(
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  fdpc_pkg::job_t push_job,
	output logic pop_valid,
	input  logic pop_ready,
	output fdpc_pkg::job_t pop_job
);
	import fdpc_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;
	assign pop_job = mem_q[rd_ptr_q];

	// job storage
	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_job;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end
endmodule

// ----- src/fdpc_back.sv -----
module fdpc_back (
	input  logic clk,
	input  logic arst_n,
	input  fdpc_pkg::cfg_t cfg_regs,
	input  logic job_valid,
	output logic job_ready,
	input  fdpc_pkg::job_t job,
	fdpc_tx_if.source tx
);
	import fdpc_pkg::*;

	bk_state_t state_q, state_d;

	logic signed [7:0] err_l_q;
	logic signed [7:0] err_r_q;
	logic chan_q;
	deg_vec_t dg_q;
	logic [DEN_W-1:0] den_q;
	logic [2:0] step_q;
	logic signed [24:0] prod_s1;
	logic signed [26:0] acc_q;
	logic neg_q;
	logic [7:0] duty_l_q;
	logic [7:0] duty_r_q;
	logic out_valid_q;
	logic [7:0] out_byte_q;
	logic out_last_q;
	logic [1:0] beat_q;

	logic signed [7:0] e_cur;
	deg_vec_t dg_now;
	logic [DEN_W-1:0] den_now;
	logic [15:0] dg_sel;
	logic signed [7:0] cen_sel;
	logic signed [24:0] prod_c;
	logic signed [26:0] acc_sum;
	logic [26:0] acc_mag;
	logic div_start;
	logic div_done;
	logic [QUO_W-1:0] div_quo;
	logic signed [16:0] corr;
	logic [7:0] duty_cur;
	logic signed [18:0] total_raw;
	logic signed [10:0] total;
	logic [7:0] duty_new;
	logic mac_last;

	// fuzzify the error of the channel in work
	assign e_cur = chan_q ? err_r_q : err_l_q;
	assign dg_now = fdpc_degrees(e_cur);
	assign den_now = DEN_W'(dg_now[SET_NB]) + DEN_W'(dg_now[SET_NS]) + DEN_W'(dg_now[SET_ZE])
		+ DEN_W'(dg_now[SET_PS]) + DEN_W'(dg_now[SET_PB]);

	// select one set per multiply-accumulate step
	always_comb begin
		case (step_q)
			3'd0: begin dg_sel = dg_q[SET_NB]; cen_sel = $signed(cfg_regs.centre[SET_NB]); end
			3'd1: begin dg_sel = dg_q[SET_NS]; cen_sel = $signed(cfg_regs.centre[SET_NS]); end
			3'd2: begin dg_sel = dg_q[SET_ZE]; cen_sel = $signed(cfg_regs.centre[SET_ZE]); end
			3'd3: begin dg_sel = dg_q[SET_PS]; cen_sel = $signed(cfg_regs.centre[SET_PS]); end
			3'd4: begin dg_sel = dg_q[SET_PB]; cen_sel = $signed(cfg_regs.centre[SET_PB]); end
			default: begin dg_sel = '0; cen_sel = '0; end
		endcase
	end

	assign prod_c = $signed({1'b0, dg_sel}) * cen_sel;
	assign acc_sum = acc_q + {{2{prod_s1[24]}}, prod_s1};
	assign acc_mag = acc_sum[26] ? 27'(-acc_sum) : acc_sum;
	assign mac_last = (step_q == 3'(NUM_SETS));

	// 256*|sum| over sum of degrees
	fdpc_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend({acc_mag[25:0], 8'd0}),
		.divisor(den_q),
		.done(div_done),
		.quotient(div_quo)
	);

	// signed correction, zero for an empty sum
	always_comb begin
		if (den_q == '0)
			corr = '0;
		else if (neg_q)
			corr = -$signed({1'b0, div_quo});
		else
			corr = $signed({1'b0, div_quo});
	end

	// new duty: truncate toward zero, then clamp ceiling first
	assign duty_cur = chan_q ? duty_r_q : duty_l_q;
	assign total_raw = $signed({3'd0, duty_cur, 8'd0}) + {{2{corr[16]}}, corr};
	assign total = total_raw[18] ? 11'((total_raw + 19'sd255) >>> 8) : 11'(total_raw >>> 8);

	always_comb begin
		if (total > $signed({3'd0, cfg_regs.pwm_ceiling}))
			duty_new = cfg_regs.pwm_ceiling;
		else if (total < $signed({3'd0, cfg_regs.pwm_floor}))
			duty_new = cfg_regs.pwm_floor;
		else
			duty_new = total[7:0];
	end

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= BK_IDLE;
		else
			state_q <= state_d;
	end

	// next state and strobes
	always_comb begin
		state_d = state_q;
		job_ready = 1'b0;
		div_start = 1'b0;
		case (state_q)
			BK_IDLE: begin
				job_ready = 1'b1;
				if (job_valid)
					state_d = BK_LOAD;
			end
			BK_LOAD: state_d = BK_MAC;
			BK_MAC: begin
				if (mac_last) begin
					if (den_q != '0) begin
						div_start = 1'b1;
						state_d = BK_DIV;
					end else begin
						state_d = BK_UPD;
					end
				end
			end
			BK_DIV: begin
				if (div_done)
					state_d = BK_UPD;
			end
			BK_UPD: state_d = chan_q ? BK_EMIT : BK_LOAD;
			BK_EMIT: begin
				if (tx.ready && beat_q == 2'd2)
					state_d = BK_IDLE;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// arithmetic datapath
	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				if (job_valid) begin
					err_l_q <= job.left_err;
					err_r_q <= job.right_err;
				end
			end
			BK_LOAD: begin
				dg_q <= dg_now;
				den_q <= den_now;
				acc_q <= '0;
			end
			BK_MAC: begin
				prod_s1 <= prod_c;
				if (step_q != '0)
					acc_q <= acc_sum;
				if (mac_last)
					neg_q <= acc_sum[26];
			end
			default: ;
		endcase
	end

	// channel, step, kept duties and output beats
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q <= 1'b0;
			step_q <= '0;
			duty_l_q <= DUTY_RESET;
			duty_r_q <= DUTY_RESET;
			out_valid_q <= 1'b0;
			out_byte_q <= '0;
			out_last_q <= 1'b0;
			beat_q <= '0;
		end else begin
			case (state_q)
				BK_IDLE: chan_q <= 1'b0;
				BK_LOAD: step_q <= '0;
				BK_MAC: step_q <= step_q + 1'b1;
				BK_UPD: begin
					if (!chan_q) begin
						duty_l_q <= duty_new;
						chan_q <= 1'b1;
					end else begin
						duty_r_q <= duty_new;
						out_valid_q <= 1'b1;
						out_byte_q <= MARKER_BYTE;
						out_last_q <= 1'b0;
						beat_q <= 2'd0;
					end
				end
				BK_EMIT: begin
					if (tx.ready) begin
						case (beat_q)
							2'd0: begin
								out_byte_q <= duty_l_q;
								beat_q <= 2'd1;
							end
							2'd1: begin
								out_byte_q <= duty_r_q;
								out_last_q <= 1'b1;
								beat_q <= 2'd2;
							end
							default: out_valid_q <= 1'b0;
						endcase
					end
				end
				default: ;
			endcase
		end
	end

	assign tx.valid = out_valid_q;
	assign tx.tx_byte = out_byte_q;
	assign tx.last_of_frame = out_last_q;
endmodule

// ----- tb/tb_top.sv -----
module tb_top;
	import fdpc_pkg::*;

	// index past the last register, writes to it must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 120;
	localparam int RANDOM_BYTES = 36;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic last_of_frame;
	} tx_beat_t;

	logic clk;
	logic arst_n;

	fdpc_rx_if rx();
	fdpc_tx_if tx();
	fdpc_cfg_if cfg();

	fuzzy_dual_pwm_controller uut (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx),
		.tx(tx),
		.cfg(cfg)
	);

	// shadow of the controller: registers, arm flags, error and duties
	logic signed [7:0] centre_m [NUM_SETS];
	logic [7:0] floor_m;
	logic [7:0] ceil_m;
	bit left_armed_m;
	bit right_armed_m;
	logic signed [7:0] left_err_m;
	logic [7:0] left_duty_m;
	logic [7:0] right_duty_m;

	tx_beat_t pwm_bytes_due[$];
	logic signed [7:0] rx_backlog[$];
	logic [CFG_IDX_W-1:0] reg_order [8];
	logic [7:0] next_regs [8];
	tx_beat_t got_beat;
	tx_beat_t due_beat;

	int bytes_queued = 0;
	int bytes_taken = 0;
	int mismatches = 0;
	int cycles = 0;
	int rx_gap = 0;
	int tx_stall = 0;
	bit calm = 1'b0;

	// q1.15 degree num/den, saturated at one
	function automatic longint membership(int num, int den);
		longint d;
		d = (longint'(num) * longint'(ONE_Q15)) / den;
		return (d > longint'(ONE_Q15)) ? longint'(ONE_Q15) : d;
	endfunction

	// fuzzify, weighted average of centres, add to duty and clamp
	function automatic logic [7:0] next_duty(int e, logic [7:0] duty);
		longint dg [NUM_SETS];
		longint wsum;
		longint dsum;
		longint corr;
		longint total;
		dg[SET_NB] = (e <= BP_NM) ? membership(BP_NM - e, BP_NM - BP_NB) : 0;
		if (e >= BP_NM && e <= BP_NS)
			dg[SET_NS] = membership(e - BP_NM, BP_NS - BP_NM);
		else if (e >= BP_NS && e <= 0)
			dg[SET_NS] = membership(-e, -BP_NS);
		else
			dg[SET_NS] = 0;
		if (e >= BP_ZL && e <= 0)
			dg[SET_ZE] = membership(e - BP_ZL, -BP_ZL);
		else if (e > 0 && e <= BP_ZR)
			dg[SET_ZE] = membership(BP_ZR - e, BP_ZR);
		else
			dg[SET_ZE] = 0;
		if (e >= 0 && e <= BP_PS)
			dg[SET_PS] = membership(e, BP_PS);
		else if (e > BP_PS && e <= BP_PM)
			dg[SET_PS] = membership(BP_PM - e, BP_PM - BP_PS);
		else
			dg[SET_PS] = 0;
		dg[SET_PB] = (e >= BP_PM) ? membership(e - BP_PM, BP_PB - BP_PM) : 0;
		wsum = 0;
		dsum = 0;
		corr = 0;
		for (int i = 0; i < NUM_SETS; i++) begin
			dsum += dg[i];
			wsum += dg[i] * longint'(centre_m[i]);
		end
		// empty sum gives no correction
		if (dsum != 0)
			corr = (wsum * 256) / dsum;
		total = (longint'(duty) * 256 + corr) / 256;
		// ceiling wins over floor when the two cross
		if (total > longint'(ceil_m))
			return ceil_m;
		else if (total < longint'(floor_m))
			return floor_m;
		return total[7:0];
	endfunction

	// advance the shadow by one accepted rx byte
	function automatic void track_rx_byte(logic signed [7:0] b);
		int c;
		c = b;
		if (b != SYNC_BYTE && right_armed_m) begin
			right_armed_m = 1'b0;
			left_duty_m = next_duty(int'(left_err_m), left_duty_m);
			right_duty_m = next_duty(c / 2, right_duty_m);
			pwm_bytes_due.push_back(tx_beat_t'{MARKER_BYTE, 1'b0});
			pwm_bytes_due.push_back(tx_beat_t'{left_duty_m, 1'b0});
			pwm_bytes_due.push_back(tx_beat_t'{right_duty_m, 1'b1});
		end else if (b != SYNC_BYTE && left_armed_m) begin
			left_err_m = b;
			left_armed_m = 1'b0;
			right_armed_m = 1'b1;
		end else if (b == SYNC_BYTE) begin
			left_armed_m = 1'b1;
		end
	endfunction

	// no gaps when calm, else mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm)
			return 0;
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 16);
		return $urandom_range(30, 120);
	endfunction

	// error byte, mostly around the breakpoints
	function automatic logic signed [7:0] pick_error(int span);
		if ($urandom_range(0, 9) < 7)
			return 8'(int'($urandom_range(0, 2 * span)) - span);
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic report_mismatch(string what, int want, int got);
		mismatches++;
		if (mismatches <= 50)
			$display("mismatch: %s expected %0d got %0d at cycle %0d", what, want, got, cycles);
	endtask

	task automatic push_byte(logic signed [7:0] b);
		rx_backlog.push_back(b);
		bytes_queued++;
	endtask

	task automatic push_frame(logic signed [7:0] left_e, logic signed [7:0] right_e);
		push_byte(SYNC_BYTE);
		push_byte(left_e);
		push_byte(right_e);
	endtask

	// write next_regs in register order, optionally the spare index too
	task automatic program_regs(input bit poke_spare);
		int n;
		n = poke_spare ? 8 : 7;
		for (int i = 0; i < n; i++) begin
			cfg.valid <= 1'b1;
			cfg.index <= reg_order[i];
			cfg.data <= next_regs[i];
			do @(posedge clk); while (!cfg.ready);
			case (reg_order[i])
				REG_CENTRE_NB: centre_m[SET_NB] = next_regs[i];
				REG_CENTRE_NS: centre_m[SET_NS] = next_regs[i];
				REG_CENTRE_ZE: centre_m[SET_ZE] = next_regs[i];
				REG_CENTRE_PS: centre_m[SET_PS] = next_regs[i];
				REG_CENTRE_PB: centre_m[SET_PB] = next_regs[i];
				REG_PWM_FLOOR: floor_m = next_regs[i];
				REG_PWM_CEIL: ceil_m = next_regs[i];
				default: ;
			endcase
		end
		cfg.valid <= 1'b0;
	endtask

	// all bytes taken, all results seen, then let the back end settle
	task automatic wait_idle();
		do @(posedge clk); while (bytes_taken != bytes_queued || pwm_bytes_due.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// mostly whole frames, some noise and some cut-off frames
	task automatic run_random(int n);
		int sent;
		int r;
		sent = 0;
		while (sent < n) begin
			r = $urandom_range(0, 99);
			if (r < 80) begin
				push_frame(pick_error(20), pick_error(40));
				sent += 3;
			end else if (r < 90) begin
				push_byte(8'($urandom_range(0, 255)));
			end else begin
				push_byte(SYNC_BYTE);
				push_byte(pick_error(20));
				sent += 2;
			end
		end
	endtask

	task automatic random_centres();
		for (int i = 0; i < NUM_SETS; i++)
			next_regs[i] = $urandom_range(0, 255);
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// rx driver: one byte per beat, random gaps between bytes
	always @(posedge clk) begin
		if (!arst_n) begin
			rx.valid <= 1'b0;
		end else begin
			if (rx.valid && rx.ready) begin
				track_rx_byte(rx.rx_byte);
				bytes_taken++;
			end
			if (!rx.valid || rx.ready) begin
				if (rx_gap > 0) begin
					rx_gap--;
					rx.valid <= 1'b0;
				end else if (rx_backlog.size() > 0) begin
					rx.valid <= 1'b1;
					rx.rx_byte <= rx_backlog.pop_front();
					rx_gap = pick_gap();
				end else begin
					rx.valid <= 1'b0;
				end
			end
		end
	end

	// tx monitor: check each beat against the oldest due byte, random stalls
	always @(posedge clk) begin
		if (!arst_n) begin
			tx.ready <= 1'b0;
		end else begin
			if (tx.valid && tx.ready) begin
				got_beat = tx_beat_t'{tx.tx_byte, tx.last_of_frame};
				if (pwm_bytes_due.size() == 0) begin
					report_mismatch("unexpected tx_byte", -1, got_beat.tx_byte);
				end else begin
					due_beat = pwm_bytes_due.pop_front();
					if (got_beat.tx_byte !== due_beat.tx_byte)
						report_mismatch("tx_byte", due_beat.tx_byte, got_beat.tx_byte);
					if (got_beat.last_of_frame !== due_beat.last_of_frame)
						report_mismatch("last_of_frame", due_beat.last_of_frame,
							got_beat.last_of_frame);
				end
			end
			if (tx_stall > 0) begin
				tx_stall--;
				tx.ready <= 1'b0;
			end else begin
				tx.ready <= 1'b1;
				if ($urandom_range(0, 5) == 0)
					tx_stall = pick_gap();
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		rx.valid = 1'b0;
		rx.rx_byte = '0;
		tx.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		reg_order = '{REG_CENTRE_NB, REG_CENTRE_NS, REG_CENTRE_ZE, REG_CENTRE_PS,
			REG_CENTRE_PB, REG_PWM_FLOOR, REG_PWM_CEIL, REG_SPARE};
		centre_m[SET_NB] = -8'sd13;
		centre_m[SET_NS] = -8'sd5;
		centre_m[SET_ZE] = 8'sd0;
		centre_m[SET_PS] = 8'sd10;
		centre_m[SET_PB] = 8'sd19;
		floor_m = 8'd6;
		ceil_m = 8'd139;
		left_armed_m = 1'b0;
		right_armed_m = 1'b0;
		left_err_m = '0;
		left_duty_m = DUTY_RESET;
		right_duty_m = DUTY_RESET;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset settings
		push_byte(8'sd5);
		push_frame(8'sd0, 8'sd0);
		// empty sum on both sides
		push_frame(-8'sd10, 8'sd20);
		// outer shoulder
		push_frame(-8'sd15, -8'sd30);
		push_frame(-8'sd128, 8'sd127);
		push_frame(8'sd127, -8'sd128);
		push_frame(8'sd7, 8'sd14);
		// odd right byte halves toward zero
		push_frame(-8'sd7, -8'sd3);
		// double sync, then sync while the right side is armed
		push_byte(SYNC_BYTE);
		push_byte(SYNC_BYTE);
		push_byte(8'sd3);
		push_byte(SYNC_BYTE);
		push_byte(8'sd4);
		push_byte(8'sd9);
		push_byte(-8'sd9);
		wait_idle();

		// random centres, wide clamp, spare index poked
		random_centres();
		next_regs[5] = $urandom_range(0, 60);
		next_regs[6] = $urandom_range(150, 255);
		next_regs[7] = $urandom_range(0, 255);
		program_regs(1'b1);
		run_random(RANDOM_BYTES);
		wait_idle();

		// extreme centres, full clamp range, no idling
		next_regs = '{8'h80, 8'h7f, 8'h80, 8'h7f, 8'h80, 8'd0, 8'd255, 8'd0};
		calm = 1'b1;
		program_regs(1'b0);
		run_random(RANDOM_BYTES);
		wait_idle();
		calm = 1'b0;

		// floor above ceiling
		next_regs = '{8'h7f, 8'h7f, 8'h7f, 8'h7f, 8'h7f, 8'd200, 8'd50, 8'h55};
		program_regs(1'b1);
		run_random(RANDOM_BYTES);
		wait_idle();

		// pull down to the floor at zero
		next_regs = '{8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'd0, 8'd255, 8'd0};
		program_regs(1'b0);
		run_random(RANDOM_BYTES);
		wait_idle();

		// random everything, floor and ceiling at the top
		random_centres();
		next_regs[5] = 8'd255;
		next_regs[6] = 8'd255;
		program_regs(1'b0);
		run_random(RANDOM_BYTES / 2);
		wait_idle();
		random_centres();
		next_regs[5] = $urandom_range(0, 255);
		next_regs[6] = $urandom_range(0, 255);
		program_regs(1'b0);
		run_random(RANDOM_BYTES / 2);
		wait_idle();

		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
